// ----- sv/irt_pkg.sv -----
// Shared types and codes for the interval range table.
// Used by irt_out_reg and interval_range_table_core.
`default_nettype none

package irt_pkg;

  localparam logic [1:0] OP_INS      = 2'd0;
  localparam logic [1:0] OP_INS_KEEP = 2'd1;
  localparam logic [1:0] OP_ERASE    = 2'd2;
  localparam logic [1:0] OP_FIND     = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_OVF   = 2'd3;

  localparam int unsigned RESULT_CAP = 16;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
    logic [31:0] tag;
    logic        found;
    logic        last;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/interval_range_table_core.sv -----
// Interval range table: sequencer scanning a sorted interval store.
// Flow: an update reads each live interval and steps through its pieces,
// writing the new table into the other bank, then commits; insert without
// overwrite then scans the new table to report its run; a find scans the live
// intervals; range errors answer without a scan. Throughput: one request at a
// time; set by the serial scan of the store. Output stalls lengthen a request. Reset: synchronous, active low; empties
// the table. Store contents are never cleared, the live count alone tells
// which entries hold data. Depends on irt_pkg, irt_mem and irt_out_reg.
`default_nettype none

module interval_range_table_core #(
  parameter int MAX_INTERVALS = 16,
  parameter int TAG_WIDTH     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [63:0] in_range_start,
  input  wire logic [63:0] in_range_length,
  input  wire logic [31:0] in_new_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_start,
  output logic [63:0]      out_length,
  output logic [31:0]      out_tag,
  output logic             out_found,
  output logic             out_last,
  output logic [1:0]       out_status
);
  import irt_pkg::*;

  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int EW = 128 + TAG_WIDTH;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_INTERVALS);
  localparam logic [4:0] CAP_M1 = 5'(RESULT_CAP - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_B      = 4'd2;
  localparam logic [3:0] S_STEP   = 4'd3;
  localparam logic [3:0] S_END    = 4'd4;
  localparam logic [3:0] S_COMMIT = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_FLAST  = 4'd7;
  localparam logic [3:0] S_RES    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [63:0] s_r, s_nxt, len_r, len_nxt, e_r, e_nxt;
  logic [TAG_WIDTH-1:0] tag_r, tag_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic bank_r, bank_nxt, ovf_r, ovf_nxt, done_r, done_nxt, ins_r, ins_nxt;
  logic find_r, find_nxt, touched_r, touched_nxt, pend_v_r, pend_v_nxt;
  logic [2:0] step_r, step_nxt;
  logic [63:0] cur_r, cur_nxt, b_r, b_nxt;
  logic [4:0] k_r, k_nxt;
  result_t res_r, res_nxt, pend_r, pend_nxt, emit_res;
  logic emit, ofree;

  logic push;
  logic [63:0] p_start, p_len;
  logic [TAG_WIDTH-1:0] p_tag;
  logic we;
  logic [EW-1:0] rdata;
  logic [63:0] a, l, lo, hi, b_sum;
  logic [TAG_WIDTH-1:0] t;
  logic [64:0] e_full;
  logic match;

  assign a = rdata[EW-1 -: 64];
  assign l = rdata[EW-65 -: 64];
  assign t = rdata[TAG_WIDTH-1:0];
  assign b_sum = a + l;
  assign lo = (a > s_r) ? a : s_r;
  assign hi = (b_r < e_r) ? b_r : e_r;
  assign match = (a < e_r) && (b_r > s_r);
  assign e_full = {1'b0, in_range_start} + {1'b0, in_range_length};
  assign we = push && !ovf_r && (j_r != MAX_C);
  assign in_stall = (state_r != S_IDLE);

  irt_mem #(.AW(IW + 1), .W(EW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr ({~bank_r, j_r[IW-1:0]}),
    .wdata ({p_start, p_len, p_tag}),
    .raddr ({bank_r, i_r[IW-1:0]}),
    .rdata (rdata)
  );

  irt_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (emit),
    .res        (emit_res),
    .free       (ofree),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_start  (out_start),
    .out_length (out_length),
    .out_tag    (out_tag),
    .out_found  (out_found),
    .out_last   (out_last),
    .out_status (out_status)
  );

  function automatic result_t mk_res(logic [63:0] st, logic [63:0] ln, logic [31:0] tg,
                                     logic fnd, logic lst, logic [1:0] stat);
    result_t r;
    r.start  = st;
    r.length = ln;
    r.tag    = tg;
    r.found  = fnd;
    r.last   = lst;
    r.status = stat;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; s_nxt = s_r; len_nxt = len_r; e_nxt = e_r; tag_nxt = tag_r;
    cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r; bank_nxt = bank_r; ovf_nxt = ovf_r;
    done_nxt = done_r; ins_nxt = ins_r; find_nxt = find_r; touched_nxt = touched_r;
    pend_v_nxt = pend_v_r; step_nxt = step_r; cur_nxt = cur_r; b_nxt = b_r;
    k_nxt = k_r; res_nxt = res_r; pend_nxt = pend_r;
    emit = 1'b0;
    emit_res = res_r;
    push = 1'b0;
    p_start = s_r;
    p_len = len_r;
    p_tag = tag_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          s_nxt = in_range_start;
          len_nxt = in_range_length;
          e_nxt = e_full[63:0];
          tag_nxt = TAG_WIDTH'(in_new_tag);
          i_nxt = '0; j_nxt = '0; k_nxt = '0; step_nxt = '0;
          ovf_nxt = 1'b0; done_nxt = 1'b0; ins_nxt = 1'b0; pend_v_nxt = 1'b0;
          cur_nxt = in_range_start;
          find_nxt = (in_op == OP_FIND);
          if (in_range_length == 64'd0) begin
            res_nxt = mk_res('0, '0, '0, 1'b0, 1'b1, STAT_EMPTY);
            state_nxt = S_RES;
          end else if (e_full[64]) begin
            res_nxt = mk_res('0, '0, '0, 1'b0, 1'b1, STAT_OVF);
            state_nxt = S_RES;
          end else if (cnt_r == '0) begin
            state_nxt = (in_op == OP_FIND) ? S_FLAST : S_END;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_B;
      S_B: begin
        b_nxt = b_sum;
        touched_nxt = !(b_sum <= s_r || a >= e_r);
        state_nxt = find_r ? S_FCHK : S_STEP;
      end
      S_STEP: begin
        unique case (step_r)
          3'd0: begin
            if (op_r == OP_INS_KEEP && !touched_r && a >= e_r && !done_r && cur_r < e_r) begin
              push = 1'b1; p_start = cur_r; p_len = e_r - cur_r;
              done_nxt = 1'b1;
            end else if (op_r == OP_INS && !ins_r && a >= s_r) begin
              push = 1'b1;
              ins_nxt = 1'b1;
            end
          end
          3'd1: begin
            if (!touched_r) begin
              push = 1'b1; p_start = a; p_len = l; p_tag = t;
            end else if (a < s_r) begin
              push = 1'b1; p_start = a; p_len = s_r - a; p_tag = t;
            end
          end
          3'd2: begin
            if (op_r == OP_INS_KEEP && touched_r && lo > cur_r) begin
              push = 1'b1; p_start = cur_r; p_len = lo - cur_r;
            end
          end
          3'd3: begin
            if (op_r == OP_INS_KEEP && touched_r) begin
              push = 1'b1; p_start = lo; p_len = hi - lo; p_tag = t;
              cur_nxt = hi;
            end
          end
          3'd4: begin
            if (op_r == OP_INS && touched_r && b_r > e_r && !ins_r) begin
              push = 1'b1;
              ins_nxt = 1'b1;
            end
          end
          3'd5: begin
            if (touched_r && b_r > e_r) begin
              push = 1'b1; p_start = e_r; p_len = b_r - e_r; p_tag = t;
            end
          end
          default: ;
        endcase
        if (step_r == 3'd5) begin
          step_nxt = '0;
          i_nxt = i_r + CW'(1);
          state_nxt = (i_r + CW'(1) == cnt_r) ? S_END : S_RD;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_END: begin
        if (op_r == OP_INS_KEEP && !done_r && cur_r < e_r) begin
          push = 1'b1; p_start = cur_r; p_len = e_r - cur_r;
        end else if (op_r == OP_INS && !ins_r) begin
          push = 1'b1;
        end
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (ovf_r) begin
          res_nxt = mk_res('0, '0, '0, 1'b0, 1'b1, STAT_FULL);
          state_nxt = S_RES;
        end else begin
          bank_nxt = ~bank_r;
          cnt_nxt = j_r;
          i_nxt = '0;
          if (op_r == OP_INS) begin
            res_nxt = mk_res(s_r, len_r, 32'(tag_r), 1'b1, 1'b1, STAT_OK);
            state_nxt = S_RES;
          end else if (op_r == OP_ERASE) begin
            res_nxt = mk_res('0, '0, '0, 1'b0, 1'b1, STAT_OK);
            state_nxt = S_RES;
          end else begin
            find_nxt = 1'b1;
            state_nxt = (j_r == '0) ? S_FLAST : S_RD;
          end
        end
      end
      S_FCHK: begin
        if (!(match && pend_v_r && !ofree)) begin
          if (match) begin
            if (pend_v_r) begin
              emit = 1'b1;
              emit_res = pend_r;
            end
            pend_nxt = mk_res(a, l, 32'(t), 1'b1, 1'b0, STAT_OK);
            pend_v_nxt = 1'b1;
            k_nxt = k_r + 5'd1;
          end
          i_nxt = i_r + CW'(1);
          if ((match && k_r == CAP_M1) || i_r + CW'(1) == cnt_r) begin
            state_nxt = S_FLAST;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_FLAST: begin
        if (ofree) begin
          emit = 1'b1;
          emit_res = pend_v_r ? mk_res(pend_r.start, pend_r.length, pend_r.tag,
                                       1'b1, 1'b1, STAT_OK)
                              : mk_res('0, '0, '0, 1'b0, 1'b1, STAT_OK);
          state_nxt = S_IDLE;
        end
      end
      S_RES: begin
        if (ofree) begin
          emit = 1'b1;
          emit_res = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // drop pieces past capacity; the commit then reports a full table
    if (push && !ovf_r) begin
      if (j_r == MAX_C) begin
        ovf_nxt = 1'b1;
      end else begin
        j_nxt = j_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      bank_r   <= 1'b0;
      pend_v_r <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      bank_r   <= bank_nxt;
      pend_v_r <= pend_v_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; s_r <= s_nxt; len_r <= len_nxt; e_r <= e_nxt; tag_r <= tag_nxt;
    i_r <= i_nxt; j_r <= j_nxt; ovf_r <= ovf_nxt; done_r <= done_nxt; ins_r <= ins_nxt;
    find_r <= find_nxt; touched_r <= touched_nxt; cur_r <= cur_nxt; b_r <= b_nxt;
    k_r <= k_nxt; res_r <= res_nxt; pend_r <= pend_nxt;
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C)
    else $error("live count exceeds capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> ofree)
    else $error("result issued while output register is held");

  a_commit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && !ovf_r) |=> (cnt_r == $past(j_r)))
    else $error("commit did not take the new count");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FCHK || state_r == S_STEP) |-> in_stall)
    else $error("input open during a scan");

endmodule

`default_nettype wire

// ----- sv/irt_mem.sv -----
// Two-bank interval store: one write port, one registered read port.
// No dependencies.
`default_nettype none

module irt_mem #(
  parameter int AW = 5,
  parameter int W  = 160
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/irt_out_reg.sv -----
// Result output register: holds one beat until the sink takes it.
// Depends on irt_pkg.
`default_nettype none

module irt_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire irt_pkg::result_t res,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [63:0]           out_start,
  output logic [63:0]           out_length,
  output logic [31:0]           out_tag,
  output logic                  out_found,
  output logic                  out_last,
  output logic [1:0]            out_status
);
  import irt_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_valid  = valid_r;
  assign out_start  = res_r.start;
  assign out_length = res_r.length;
  assign out_tag    = res_r.tag;
  assign out_found  = res_r.found;
  assign out_last   = res_r.last;
  assign out_status = res_r.status;

endmodule

`default_nettype wire

// ----- test/interval_range_table_core_tb.sv -----
// Testbench for interval_range_table_core: drives requests and checks every result beat.
// Expected beats come from a behavioral interval table kept in this file.
// Depends on irt_pkg and interval_range_table_core.
`timescale 1ns / 1ps

module interval_range_table_core_tb;
  import irt_pkg::*;

  localparam int NSLOT = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_FIND;
  logic [63:0] in_range_start = '0;
  logic [63:0] in_range_length = '0;
  logic [31:0] in_new_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_start;
  logic [63:0] out_length;
  logic [31:0] out_tag;
  logic out_found;
  logic out_last;
  logic [1:0] out_status;

  interval_range_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_range_start(in_range_start), .in_range_length(in_range_length),
    .in_new_tag(in_new_tag),
    .out_valid(out_valid), .out_stall(out_stall), .out_start(out_start),
    .out_length(out_length), .out_tag(out_tag), .out_found(out_found),
    .out_last(out_last), .out_status(out_status)
  );

  always #6 clk = ~clk;

  // table shadow
  logic [63:0] tbl_start [NSLOT];
  logic [63:0] tbl_len [NSLOT];
  logic [31:0] tbl_tag [NSLOT];
  int tbl_cnt = 0;

  result_t pending_beats[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // rebuild scratch
  logic [63:0] nx_start [48];
  logic [63:0] nx_len [48];
  logic [31:0] nx_tag [48];
  bit nx_hit [48];
  int nx_cnt;

  function automatic void nx_push(logic [63:0] a, logic [63:0] l, logic [31:0] t, bit h);
    if (nx_cnt < 48) begin
      nx_start[nx_cnt] = a; nx_len[nx_cnt] = l; nx_tag[nx_cnt] = t; nx_hit[nx_cnt] = h;
    end
    nx_cnt++;
  endfunction

  function automatic bit nx_commit();
    if (nx_cnt > NSLOT) return 1'b0;
    for (int i = 0; i < nx_cnt; i++) begin
      tbl_start[i] = nx_start[i]; tbl_len[i] = nx_len[i]; tbl_tag[i] = nx_tag[i];
    end
    tbl_cnt = nx_cnt;
    return 1'b1;
  endfunction

  function automatic result_t beat(logic [63:0] a, logic [63:0] l, logic [31:0] t,
                                   bit f, bit lst, logic [1:0] st);
    result_t r;
    r.start = a; r.length = l; r.tag = t; r.found = f; r.last = lst; r.status = st;
    return r;
  endfunction

  function automatic void cut_range(logic [63:0] s, logic [63:0] e);
    logic [63:0] a, b;
    nx_cnt = 0;
    for (int i = 0; i < tbl_cnt; i++) begin
      a = tbl_start[i]; b = a + tbl_len[i];
      if (b <= s || a >= e) nx_push(a, tbl_len[i], tbl_tag[i], 0);
      else begin
        if (a < s) nx_push(a, s - a, tbl_tag[i], 0);
        if (b > e) nx_push(e, b - e, tbl_tag[i], 0);
      end
    end
  endfunction

  // Apply one request to the shadow table and queue the beats it yields.
  function automatic void predict_table_op(logic [1:0] op, logic [63:0] s, logic [63:0] l,
                                           logic [31:0] t);
    logic [63:0] e, a, b, lo, hi, cur;
    int n, pos;
    bit done;
    result_t run[$];
    e = s + l;
    if (l == 0) begin
      pending_beats.push_back(beat(0, 0, 0, 0, 1, STAT_EMPTY));
      return;
    end
    if (e < s) begin
      pending_beats.push_back(beat(0, 0, 0, 0, 1, STAT_OVF));
      return;
    end
    case (op)
      OP_FIND: begin
        for (int i = 0; i < tbl_cnt; i++) begin
          a = tbl_start[i]; b = a + tbl_len[i];
          if (a < e && b > s && run.size() < RESULT_CAP)
            run.push_back(beat(a, tbl_len[i], tbl_tag[i], 1, 0, STAT_OK));
        end
      end
      OP_ERASE: begin
        cut_range(s, e);
        pending_beats.push_back(beat(0, 0, 0, 0, 1, nx_commit() ? STAT_OK : STAT_FULL));
        return;
      end
      OP_INS: begin
        cut_range(s, e);
        n = nx_cnt;
        if (n + 1 > NSLOT) begin
          pending_beats.push_back(beat(0, 0, 0, 0, 1, STAT_FULL));
          return;
        end
        pos = 0;
        while (pos < n && nx_start[pos] < s) pos++;
        for (int i = n; i > pos; i--) begin
          nx_start[i] = nx_start[i-1]; nx_len[i] = nx_len[i-1]; nx_tag[i] = nx_tag[i-1];
        end
        nx_start[pos] = s; nx_len[pos] = l; nx_tag[pos] = t;
        nx_cnt = n + 1;
        void'(nx_commit());
        pending_beats.push_back(beat(s, l, t, 1, 1, STAT_OK));
        return;
      end
      default: begin
        cur = s; done = 0; nx_cnt = 0;
        for (int i = 0; i < tbl_cnt; i++) begin
          a = tbl_start[i]; b = a + tbl_len[i];
          if (b <= s) nx_push(a, tbl_len[i], tbl_tag[i], 0);
          else if (a >= e) begin
            if (!done) begin
              if (cur < e) nx_push(cur, e - cur, t, 1);
              done = 1;
            end
            nx_push(a, tbl_len[i], tbl_tag[i], 0);
          end else begin
            lo = (a > s) ? a : s;
            hi = (b < e) ? b : e;
            if (a < s) nx_push(a, s - a, tbl_tag[i], 0);
            if (lo > cur) nx_push(cur, lo - cur, t, 1);
            nx_push(lo, hi - lo, tbl_tag[i], 1);
            cur = hi;
            if (b > e) nx_push(e, b - e, tbl_tag[i], 0);
          end
        end
        if (!done && cur < e) nx_push(cur, e - cur, t, 1);
        if (!nx_commit()) begin
          pending_beats.push_back(beat(0, 0, 0, 0, 1, STAT_FULL));
          return;
        end
        for (int i = 0; i < nx_cnt; i++)
          if (nx_hit[i] && run.size() < RESULT_CAP)
            run.push_back(beat(nx_start[i], nx_len[i], nx_tag[i], 1, 0, STAT_OK));
      end
    endcase
    if (run.size() == 0) run.push_back(beat(0, 0, 0, 0, 1, STAT_OK));
    else run[run.size()-1].last = 1'b1;
    foreach (run[i]) pending_beats.push_back(run[i]);
  endfunction

  // Valid stays up after the accepting edge until the next call or a drain drops it.
  task automatic send_request(logic [1:0] op, logic [63:0] s, logic [63:0] l, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op; in_range_start <= s; in_range_length <= l; in_new_tag <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table_op(op, s, l, t);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    result_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_b = pending_beats.pop_front();
        if (out_start !== exp_b.start) begin
          $error("out_start exp %h got %h", exp_b.start, out_start); errors++;
        end
        if (out_length !== exp_b.length) begin
          $error("out_length exp %h got %h", exp_b.length, out_length); errors++;
        end
        if (out_tag !== exp_b.tag) begin
          $error("out_tag exp %h got %h", exp_b.tag, out_tag); errors++;
        end
        if (out_found !== exp_b.found) begin
          $error("out_found exp %b got %b", exp_b.found, out_found); errors++;
        end
        if (out_last !== exp_b.last) begin
          $error("out_last exp %b got %b", exp_b.last, out_last); errors++;
        end
        if (out_status !== exp_b.status) begin
          $error("out_status exp %0d got %0d", exp_b.status, out_status); errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_edge_cases();
    send_request(OP_FIND, 64'd100, 64'd10, 32'h0);
    send_request(OP_INS, 64'd100, 64'd0, 32'h1);
    send_request(OP_INS_KEEP, '1, 64'd2, 32'h2);
    send_request(OP_INS, 64'd100, 64'd50, '1);
    send_request(OP_INS, 64'd200, 64'd20, 32'h5);
    send_request(OP_FIND, 64'd150, 64'd50, 32'h0);
    send_request(OP_FIND, 64'd149, 64'd2, 32'h0);
    send_request(OP_INS_KEEP, 64'd90, 64'd200, 32'hA5A5_5A5A);
    send_request(OP_ERASE, 64'd120, 64'd10, 32'h0);
    send_request(OP_INS, 64'd110, 64'd100, 32'h7);
    send_request(OP_FIND, 64'd0, '1, 32'h0);
    send_request(OP_ERASE, 64'd0, '1, 32'h0);
    send_request(OP_INS, '1, 64'd1, 32'h9);
    send_request(OP_INS, 64'd0, 64'd1, 32'h3);
    send_request(OP_INS, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'h4);
    send_request(OP_FIND, 64'd0, '1, 32'h0);
    send_request(OP_ERASE, 64'd0, '1, 32'h0);
  endtask

  // Fill the table with many small intervals to hit full and long runs.
  task automatic test_full_table();
    for (int i = 0; i < 17; i++)
      send_request(OP_INS, 64'd1000 + 64'(i) * 10, 64'd5, 32'(i));
    send_request(OP_ERASE, 64'd1002, 64'd1, 32'h0);
    send_request(OP_INS_KEEP, 64'd990, 64'd200, 32'hBEEF);
    send_request(OP_FIND, 64'd0, 64'd5000, 32'h0);
    wait_drained();
    send_request(OP_ERASE, 64'd0, '1, 32'h0);
  endtask

  task automatic test_random(int count);
    logic [1:0] op;
    logic [63:0] s, l;
    for (int i = 0; i < count; i++) begin
      op = 2'($urandom_range(3));
      case ($urandom_range(19))
        0: begin s = rand64(); l = rand64(); end
        1: begin s = rand64(); l = 0; end
        2: begin s = 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(255); l = $urandom_range(300); end
        default: begin s = $urandom_range(400); l = 1 + $urandom_range(40); end
      endcase
      if ($urandom_range(24) == 0) wait_drained();
      send_request(op, s, l, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26; recv_idle_pct = 85;
    test_edge_cases();
    test_full_table();
    test_random(80);
    send_idle_pct = 85; recv_idle_pct = 26;
    test_random(80);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(82);
    wait_drained();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

endmodule
